// ===== rtl/core/rrpia_pkg.sv =====
// ---------------------------------------------------------------------------
// rrpia_pkg
// Shared types, codes and default sizes for the identifier allocator.
// ---------------------------------------------------------------------------
package rrpia_pkg;

	// default sizes
	localparam int ID_BITS    = 16;
	localparam int WORD_BITS  = 64;
	localparam int FIELD_ID_W = 16;
	localparam int ACTION_W   = 2;

	// request action codes on the input port
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

	// classified request kind, front to back
	typedef enum logic [1:0] {
		K_NOP,
		K_ALLOC,
		K_RELEASE,
		K_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [FIELD_ID_W-1:0]  id;
	} cmd_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL
	} back_state_t;

	// back end status seen by the top level
	typedef struct packed {
		logic clearing;
		logic cmd_pop;
	} back_stat_t;

endpackage

// ===== rtl/core/rrpia_ram.sv =====
// ---------------------------------------------------------------------------
// rrpia_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module rrpia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/rrpia_front.sv =====
// ---------------------------------------------------------------------------
// rrpia_front
// Classifies incoming requests and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module rrpia_front #(
	parameter int ID_BITS = rrpia_pkg::ID_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr,
	input  logic [rrpia_pkg::ACTION_W-1:0]        action,
	input  logic [rrpia_pkg::FIELD_ID_W-1:0]      packet_id,
	output logic                                  q_full,
	output logic                                  cmd_valid,
	output rrpia_pkg::cmd_t                       cmd,
	input  logic                                  cmd_pop
);

	rrpia_pkg::cmd_t  entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	rrpia_pkg::cmd_t  cls;
	logic [ID_BITS-1:0] id_trunc;

	// classify: identifier zero on release or query does nothing
	always_comb begin
		id_trunc = packet_id[ID_BITS-1:0];
		cls.id   = rrpia_pkg::FIELD_ID_W'(id_trunc);
		case (action)
			rrpia_pkg::ACT_ALLOC:   cls.kind = rrpia_pkg::K_ALLOC;
			rrpia_pkg::ACT_RELEASE: cls.kind = (id_trunc != '0) ? rrpia_pkg::K_RELEASE
			                                                    : rrpia_pkg::K_NOP;
			rrpia_pkg::ACT_QUERY:   cls.kind = (id_trunc != '0) ? rrpia_pkg::K_QUERY
			                                                    : rrpia_pkg::K_NOP;
			default:                cls.kind = rrpia_pkg::K_NOP;
		endcase
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!wr && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign q_full    = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];

endmodule

// ===== rtl/core/rrpia_back.sv =====
// ---------------------------------------------------------------------------
// rrpia_back
// Bitmap sequencer: clearing pass, word scan for allocate, read-modify-write
// for release, lookup for query, and the result register.
// ---------------------------------------------------------------------------
module rrpia_back #(
	parameter int ID_BITS   = rrpia_pkg::ID_BITS,
	parameter int WORD_BITS = rrpia_pkg::WORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	input  rrpia_pkg::cmd_t                      cmd,
	output rrpia_pkg::back_stat_t                stat,
	output logic                                 res_valid,
	output logic [rrpia_pkg::FIELD_ID_W-1:0]     res_id,
	output logic                                 res_in_use,
	input  logic                                 res_pop
);

	localparam int WB_LOG    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int NUM_WORDS = ((2 ** ID_BITS) + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	// bits of a word that map to real identifiers
	function automatic logic [WORD_BITS-1:0] range_mask();
		logic [WORD_BITS-1:0] m;
		m = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (i < (2 ** ID_BITS));
		end
		return m;
	endfunction

	localparam logic [WORD_BITS-1:0] RANGE_MASK = range_mask();
	localparam logic [AW-1:0]        LAST_WORD  = AW'(NUM_WORDS - 1);

	rrpia_pkg::back_state_t state_q, state_n;
	rrpia_pkg::cmd_kind_t   kind_q;
	logic [AW-1:0]          clr_addr_q;
	logic [AW-1:0]          word_q, word_n;
	logic [WB_LOG-1:0]      off_q, off_n;
	logic                   ld_scan;
	logic [ID_BITS-1:0]     cand_q, cand_n;
	logic [ID_BITS-1:0]     count_q;
	logic                   cnt_inc, cnt_dec, cand_ld;
	logic                   out_valid_q;
	logic [ID_BITS-1:0]     out_id_q, out_id_n;
	logic                   out_use_q, out_use_n;
	logic                   out_ld;
	logic                   pop_cmd;
	logic [ID_BITS-1:0]     cid;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;
	logic [WORD_BITS-1:0]   free_w, bit_oh, sel_oh;
	logic                   found;
	logic [WB_LOG-1:0]      fbit;
	logic [ID_BITS-1:0]     found_id, found_nx;

	rrpia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// free bits at or above the scan offset; identifier zero never free
	always_comb begin
		free_w = ~ram_rdata & RANGE_MASK & ({WORD_BITS{1'b1}} << off_q);
		if (word_q == '0) begin
			free_w[0] = 1'b0;
		end
		found = (free_w != '0);
		fbit  = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_w[i]) begin
				fbit = WB_LOG'(i);
			end
		end
		sel_oh   = WORD_BITS'(1) << fbit;
		bit_oh   = WORD_BITS'(1) << off_q;
		found_id = ID_BITS'({word_q, fbit});
		found_nx = found_id + ID_BITS'(1);
		if (found_nx == '0) begin
			found_nx = ID_BITS'(1);
		end
	end

	assign cid = cmd.id[ID_BITS-1:0];

	// sequencer next state and datapath controls
	always_comb begin
		state_n   = state_q;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata;
		ram_raddr = word_q;
		word_n    = word_q;
		off_n     = off_q;
		ld_scan   = 1'b0;
		pop_cmd   = 1'b0;
		out_ld    = 1'b0;
		out_id_n  = '0;
		out_use_n = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		cand_ld   = 1'b0;
		cand_n    = found_nx;
		case (state_q)
			rrpia_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == LAST_WORD) begin
					state_n = rrpia_pkg::ST_IDLE;
				end
			end
			rrpia_pkg::ST_IDLE: begin
				if (cmd_valid && (!out_valid_q || res_pop)) begin
					pop_cmd = 1'b1;
					case (cmd.kind)
						rrpia_pkg::K_ALLOC: begin
							if (count_q == '1) begin
								out_ld = 1'b1;
							end else begin
								ld_scan = 1'b1;
								word_n  = AW'(cand_q >> WB_LOG);
								off_n   = WB_LOG'(cand_q);
								state_n = rrpia_pkg::ST_EVAL;
							end
						end
						rrpia_pkg::K_RELEASE, rrpia_pkg::K_QUERY: begin
							ld_scan = 1'b1;
							word_n  = AW'(cid >> WB_LOG);
							off_n   = WB_LOG'(cid);
							state_n = rrpia_pkg::ST_EVAL;
						end
						default: begin
							out_ld = 1'b1;
						end
					endcase
					ram_raddr = word_n;
				end
			end
			rrpia_pkg::ST_EVAL: begin
				case (kind_q)
					rrpia_pkg::K_ALLOC: begin
						if (found) begin
							ram_we    = 1'b1;
							ram_wdata = ram_rdata | sel_oh;
							out_ld    = 1'b1;
							out_id_n  = found_id;
							cnt_inc   = 1'b1;
							cand_ld   = 1'b1;
							state_n   = rrpia_pkg::ST_IDLE;
						end else begin
							// move on to the next word, wrapping round
							word_n    = (word_q == LAST_WORD) ? '0 : word_q + AW'(1);
							off_n     = '0;
							ram_raddr = word_n;
						end
					end
					rrpia_pkg::K_RELEASE: begin
						if (ram_rdata[off_q]) begin
							ram_we    = 1'b1;
							ram_wdata = ram_rdata & ~bit_oh;
							cnt_dec   = 1'b1;
						end
						out_ld  = 1'b1;
						state_n = rrpia_pkg::ST_IDLE;
					end
					rrpia_pkg::K_QUERY: begin
						out_ld    = 1'b1;
						out_use_n = ram_rdata[off_q];
						state_n   = rrpia_pkg::ST_IDLE;
					end
					default: begin
						state_n = rrpia_pkg::ST_IDLE;
					end
				endcase
			end
			default: begin
				state_n = rrpia_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrpia_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			cand_q      <= ID_BITS'(1);
			count_q     <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= rrpia_pkg::K_NOP;
		end else begin
			if (state_q == rrpia_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cand_ld) begin
				cand_q <= cand_n;
			end
			if (cnt_inc) begin
				count_q <= count_q + ID_BITS'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - ID_BITS'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
			if (ld_scan) begin
				kind_q <= cmd.kind;
			end
		end
	end

	// scan position and result payload
	always_ff @(posedge clk) begin
		word_q <= word_n;
		off_q  <= off_n;
		if (out_ld) begin
			out_id_q  <= out_id_n;
			out_use_q <= out_use_n;
		end
	end

	assign stat.clearing = (state_q == rrpia_pkg::ST_CLEAR);
	assign stat.cmd_pop  = pop_cmd;
	assign res_valid     = out_valid_q;
	assign res_id        = rrpia_pkg::FIELD_ID_W'(out_id_q);
	assign res_in_use    = out_use_q;

endmodule

// ===== rtl/core/round_robin_packet_id_allocator.sv =====
// ---------------------------------------------------------------------------
// round_robin_packet_id_allocator
// Round-robin bitmap identifier allocator with queue-style ports.
//
// Hands out identifiers 1..2^ID_BITS-1 from a used bitmap held in RAM,
// one WORD_BITS-wide word per read. After reset the bitmap is cleared one
// word a cycle (2^ID_BITS/WORD_BITS words, 1024 by default) and full stays
// high until that pass ends. Each request gives exactly one result. With the
// back end free, a release or query is dispatched from the queue with the
// RAM read, then evaluated and written back, and its result is registered.
// An allocate scans from the next-candidate pointer one bitmap word per
// cycle, passing over each fully used word until it finds a free bit; with
// all identifiers used it answers 0 without a scan. A two-entry request
// queue takes new requests while the back end works or a result waits.
// ---------------------------------------------------------------------------
module round_robin_packet_id_allocator #(
	parameter int ID_BITS   = rrpia_pkg::ID_BITS,
	parameter int WORD_BITS = rrpia_pkg::WORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [rrpia_pkg::ACTION_W-1:0]       action,
	input  logic [rrpia_pkg::FIELD_ID_W-1:0]     packet_id,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [rrpia_pkg::FIELD_ID_W-1:0]     result_id,
	output logic                                 in_use
);

	logic                  q_full;
	logic                  wr;
	logic                  cmd_valid;
	rrpia_pkg::cmd_t       cmd;
	rrpia_pkg::back_stat_t stat;
	logic                  res_valid;

	// no requests during the clearing pass
	assign full = q_full | stat.clearing;
	assign wr   = push & ~full;

	rrpia_front #(
		.ID_BITS (ID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.action    (action),
		.packet_id (packet_id),
		.q_full    (q_full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (stat.cmd_pop)
	);

	rrpia_back #(
		.ID_BITS   (ID_BITS),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.stat       (stat),
		.res_valid  (res_valid),
		.res_id     (result_id),
		.res_in_use (in_use),
		.res_pop    (pop & res_valid)
	);

	assign empty = ~res_valid;

`ifndef SYNTHESIS
	// back end only takes requests that are queued
	a_pop_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cmd_pop |-> cmd_valid)
		else $error("request taken from an empty queue");

	// nothing dispatched while the bitmap is being cleared
	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !stat.cmd_pop)
		else $error("request dispatched during clearing pass");

	// a waiting result is not lost before it is taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_id) && $stable(in_use)))
		else $error("waiting result changed or dropped");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin identifier allocator. A queue of
// requests feeds a clocked driver; a clocked monitor compares every result
// against a bitmap-based predictor updated in request acceptance order.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int MAX_ID   = (1 << rrpia_pkg::ID_BITS) - 1;
	localparam int WDOG_MAX = 20000;
	// action code with no meaning; the block must answer 0 and change nothing
	localparam logic [rrpia_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [rrpia_pkg::ACTION_W-1:0]   act;
		logic [rrpia_pkg::FIELD_ID_W-1:0] id;
	} request_t;

	typedef struct {
		logic [rrpia_pkg::FIELD_ID_W-1:0] rid;
		logic                             used;
	} answer_t;

	logic                             clk;
	logic                             arst_n;
	logic                             push;
	logic                             full;
	logic [rrpia_pkg::ACTION_W-1:0]   action;
	logic [rrpia_pkg::FIELD_ID_W-1:0] packet_id;
	logic                             empty;
	logic                             pop;
	logic [rrpia_pkg::FIELD_ID_W-1:0] result_id;
	logic                             in_use;

	// predictor state
	bit        id_used [0:MAX_ID];
	int        next_cand;
	int        n_used;

	request_t  pending_reqs[$];
	answer_t   expected_answers[$];
	int        n_errors;
	int        n_sent;
	int        n_checked;
	int        n_allocs;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_cycles;
	bit        stim_done;
	int        wdog;

	round_robin_packet_id_allocator dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(action), .packet_id(packet_id), .empty(empty), .pop(pop),
		.result_id(result_id), .in_use(in_use)
	);

	// clock
	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	function automatic int next_id(int id);
		int n;
		n = (id + 1) & MAX_ID;
		return (n == 0) ? 1 : n;
	endfunction

	// expected outcome of one accepted request, updating the predicted bitmap
	function automatic answer_t predict_allocator(request_t r);
		answer_t a;
		int      c;
		int      id;
		a.rid = '0;
		a.used = 1'b0;
		id = int'(r.id) & MAX_ID;
		if (r.act == rrpia_pkg::ACT_ALLOC) begin
			c = next_cand & MAX_ID;
			if (c == 0)
				c = 1;
			if (n_used < MAX_ID) begin
				for (int t = 0; t < MAX_ID; t++) begin
					if (!id_used[c]) begin
						id_used[c] = 1'b1;
						n_used++;
						next_cand = next_id(c);
						a.rid = rrpia_pkg::FIELD_ID_W'(c);
						break;
					end
					c = next_id(c);
				end
			end
		end else if (r.act == rrpia_pkg::ACT_RELEASE) begin
			if (id != 0 && id_used[id]) begin
				id_used[id] = 1'b0;
				if (n_used > 0)
					n_used--;
			end
		end else if (r.act == rrpia_pkg::ACT_QUERY) begin
			a.used = (id != 0) && id_used[id];
		end
		return a;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic queue_req(logic [rrpia_pkg::ACTION_W-1:0] a,
			logic [rrpia_pkg::FIELD_ID_W-1:0] id);
		request_t r;
		r.act = a;
		r.id = id;
		pending_reqs.push_back(r);
	endtask

	// random request mix: mostly allocate/release of likely-used ids
	task automatic queue_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 40)
				queue_req(rrpia_pkg::ACT_ALLOC, 16'($urandom));
			else if (k < 65)
				queue_req(rrpia_pkg::ACT_RELEASE, 16'($urandom_range(1, 600)));
			else if (k < 85)
				queue_req(rrpia_pkg::ACT_QUERY, 16'($urandom_range(0, 600)));
			else if (k < 95)
				queue_req(2'($urandom_range(1, 2)), 16'($urandom));
			else
				queue_req(ACT_UNUSED, 16'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || push || expected_answers.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			action <= '0;
			packet_id <= '0;
		end else begin
			if (push && !full) begin
				expected_answers.push_back(predict_allocator('{action, packet_id}));
				n_sent++;
			end
			if (!(push && full)) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					action <= pending_reqs[0].act;
					packet_id <= pending_reqs[0].id;
					void'(pending_reqs.pop_front());
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					e = expected_answers.pop_front();
					if (result_id !== e.rid)
						report_mismatch($sformatf("result_id %0d, want %0d", result_id, e.rid));
					if (in_use !== e.used)
						report_mismatch($sformatf("in_use %0b, want %0b", in_use, e.used));
					if (e.rid != 0)
						n_allocs++;
				end
				n_checked++;
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if (arst_n && !stim_done) begin
			if ((push && !full) || (pop && !empty))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WDOG_MAX) begin
				$display("watchdog expired after %0d idle cycles", wdog);
				$display("[round_robin_packet_id_allocator] ERROR");
				$finish;
			end
		end
	end

	initial begin
		n_errors = 0; n_sent = 0; n_checked = 0; n_allocs = 0;
		send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
		stim_done = 1'b0; wdog = 0;
		for (int i = 0; i <= MAX_ID; i++)
			id_used[i] = 1'b0;
		next_cand = 1;
		n_used = 0;
		arst_n = 1'b0;
		push = 1'b0; pop = 1'b0; action = '0; packet_id = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, id zero, free release, unused code
		queue_req(rrpia_pkg::ACT_QUERY, 16'd0);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'd0);
		queue_req(rrpia_pkg::ACT_ALLOC, 16'hFFFF);
		queue_req(rrpia_pkg::ACT_ALLOC, 16'd0);
		queue_req(rrpia_pkg::ACT_QUERY, 16'd1);
		queue_req(rrpia_pkg::ACT_QUERY, 16'hFFFF);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'hFFFF);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'd1);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'd1);
		queue_req(rrpia_pkg::ACT_QUERY, 16'd1);
		queue_req(ACT_UNUSED, 16'hFFFF);
		queue_req(ACT_UNUSED, 16'd2);
		queue_req(rrpia_pkg::ACT_ALLOC, 16'h5555);
		queue_req(rrpia_pkg::ACT_QUERY, 16'd3);
		queue_req(rrpia_pkg::ACT_QUERY, 16'hAAAA);
		wait_drained();

		// no idling
		queue_random(200);
		wait_drained();

		// long receiver hold while requests keep coming, so the input stalls
		hold_cycles = 300;
		queue_random(60);
		wait_drained();

		send_idle_pct = 54;
		queue_random(200);
		wait_drained();
		send_idle_pct = 0; recv_idle_pct = 54;
		queue_random(200);
		wait_drained();
		send_idle_pct = 22; recv_idle_pct = 22;
		queue_random(200);
		wait_drained();
		send_idle_pct = 0; recv_idle_pct = 0;

		// run of allocates across bitmap words, free a few and rescan
		for (int i = 0; i < 40; i++)
			queue_req(rrpia_pkg::ACT_ALLOC, 16'($urandom));
		wait_drained();
		queue_req(rrpia_pkg::ACT_QUERY, 16'hFFFF);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'd1);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'hFFFF);
		queue_req(rrpia_pkg::ACT_RELEASE, 16'd40000);
		for (int i = 0; i < 5; i++)
			queue_req(rrpia_pkg::ACT_ALLOC, 16'd0);
		queue_random(80);
		wait_drained();

		stim_done = 1'b1;
		repeat (1100) @(posedge clk);
		if (expected_answers.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
		$display("covered %0d requests, %0d results, %0d ids handed out",
			n_sent, n_checked, n_allocs);
		$display("included id zero, free release, unused action and stalls on both sides");
		if (n_errors == 0)
			$display("[round_robin_packet_id_allocator] OK");
		else
			$display("[round_robin_packet_id_allocator] ERROR");
		$finish;
	end

endmodule
